@@ rtl/wsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wiper sweep controller package
// Shared widths, codes, fixed timing constants and a small helper function.
// ----------------------------------------------------------------------------
package wsc_pkg;

    // Default knob level width; thresholds share it.
    localparam int LEVEL_BITS_DEF = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Millisecond counter and output widths.
    localparam int MS_W    = 16;
    localparam int ANGLE_W = 7;
    localparam int PHASE_W = 2;

    // Length of one tick in milliseconds.
    localparam int TICK_MS = 10;

    localparam logic [MS_W-1:0]    LOW_SWING_MS  = 16'd1000;
    localparam logic [MS_W-1:0]    HIGH_SWING_MS = 16'd400;
    localparam logic [MS_W-1:0]    COUNT_MAX     = 16'hFFFF;
    localparam logic [ANGLE_W-1:0] UP_ANGLE      = 7'd67;
    localparam logic [ANGLE_W-1:0] PARK_ANGLE    = 7'd0;

    // Reset pause lengths in milliseconds.
    localparam logic [MS_W-1:0] SHORT_PAUSE_RST  = 16'd3000;
    localparam logic [MS_W-1:0] MEDIUM_PAUSE_RST = 16'd5000;
    localparam logic [MS_W-1:0] LONG_PAUSE_RST   = 16'd8000;

    // Reported phase codes.
    localparam logic [PHASE_W-1:0] PH_UP   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DOWN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_BELOW          = 3'd0,
        CFG_LOW_BELOW          = 3'd1,
        CFG_INTERMITTENT_BELOW = 3'd2,
        CFG_SHORT_BELOW        = 3'd3,
        CFG_MEDIUM_BELOW       = 3'd4,
        CFG_SHORT_PAUSE_MS     = 3'd5,
        CFG_MEDIUM_PAUSE_MS    = 3'd6,
        CFG_LONG_PAUSE_MS      = 3'd7
    } t_cfg_idx;

    // Wiper mode selected by the mode knob.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_INT  = 2'd2,
        MODE_HIGH = 2'd3
    } t_mode;

    // Sweep phase machine, one-hot.
    typedef enum logic [2:0] {
        SW_UP   = 3'b001,
        SW_DOWN = 3'b010,
        SW_HOLD = 3'b100
    } t_sweep;

    function automatic logic [PHASE_W-1:0] phase_code(input t_sweep s);
        logic [PHASE_W-1:0] c;
        case (s)
            SW_UP:   c = PH_UP;
            SW_DOWN: c = PH_DOWN;
            default: c = PH_HOLD;
        endcase
        return c;
    endfunction

endpackage : wsc_pkg
`default_nettype wire

@@ rtl/wsc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wiper sweep controller channels
// Valid/ready interfaces for tick requests, results and register writes.
// ----------------------------------------------------------------------------
interface wsc_tick_if
    import wsc_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  ignition_on;
    logic [LEVEL_BITS-1:0] switch_level;
    logic [LEVEL_BITS-1:0] pause_level;

    modport source (output valid, ignition_on, switch_level, pause_level, input ready);
    modport sink   (input valid, ignition_on, switch_level, pause_level, output ready);
endinterface : wsc_tick_if

interface wsc_result_if
    import wsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] wiper_angle;
    logic               fast_speed;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, wiper_angle, fast_speed, phase, input ready);
    modport sink   (input valid, wiper_angle, fast_speed, phase, output ready);
endinterface : wsc_result_if

interface wsc_cfg_if
    import wsc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : wsc_cfg_if
`default_nettype wire

@@ rtl/wiper_sweep_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wiper sweep controller
// Decodes the mode and pause knobs, runs the up/down/hold sweep phase
// machine with a saturating millisecond timer, and reports the servo target.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Moves                                     Handshake
//  i_tick    in         ignition_on, switch_level, pause_level    valid/ready
//  o_result  out        wiper_angle, fast_speed, phase            valid/ready
//  i_cfg     in         register index, write data                valid/ready
//
// Each request yields exactly one registered result. A new request is taken
// every cycle unless stalled; the output register is the only stage, so a
// request is accepted whenever that register is empty or is being drained
// in the same cycle. A stall on o_result holds the result and the state and
// pushes back on i_tick. Reset (i_rst_n low, synchronous) loads the
// register defaults, puts the phase machine in hold, clears the timer and
// selects low speed. Register writes are always accepted.
//
module wiper_sweep_controller
    import wsc_pkg::*;
#(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    wsc_tick_if.sink     i_tick,
    wsc_result_if.source o_result,
    wsc_cfg_if.sink      i_cfg
);

    // Reset thresholds are fixed fractions of full scale, rounded to nearest.
    localparam longint FULL_SCALE = longint'(1) << LEVEL_BITS;
    localparam logic [LEVEL_BITS-1:0] OFF_RST =
        LEVEL_BITS'((FULL_SCALE * 2 + 5) / 10);
    localparam logic [LEVEL_BITS-1:0] LOW_RST =
        LEVEL_BITS'((FULL_SCALE * 4 + 5) / 10);
    localparam logic [LEVEL_BITS-1:0] INT_RST =
        LEVEL_BITS'((FULL_SCALE * 6 + 5) / 10);
    localparam logic [LEVEL_BITS-1:0] SHORT_RST =
        LEVEL_BITS'((FULL_SCALE * 33 + 50) / 100);
    localparam logic [LEVEL_BITS-1:0] MEDIUM_RST =
        LEVEL_BITS'((FULL_SCALE * 66 + 50) / 100);

    localparam int SUM_W = MS_W + 1;

    // Configuration registers.
    logic [LEVEL_BITS-1:0] r_off_below;
    logic [LEVEL_BITS-1:0] r_low_below;
    logic [LEVEL_BITS-1:0] r_int_below;
    logic [LEVEL_BITS-1:0] r_short_below;
    logic [LEVEL_BITS-1:0] r_medium_below;
    logic [MS_W-1:0]       r_short_pause;
    logic [MS_W-1:0]       r_medium_pause;
    logic [MS_W-1:0]       r_long_pause;

    // Sweep state.
    t_sweep          r_sweep;
    t_sweep          n_sweep;
    logic [MS_W-1:0] r_elapsed;
    logic [MS_W-1:0] n_elapsed;
    logic            r_fast_sel;
    logic            n_fast_sel;

    // Output register.
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] n_angle;
    logic               r_fast;
    logic               n_fast;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;

    logic tick_accept;

    // The output register parts the two sides: take a request when it is
    // free or is being emptied in this cycle.
    assign i_tick.ready = !r_out_valid || o_result.ready;
    assign tick_accept  = i_tick.valid && i_tick.ready;

    assign i_cfg.ready = 1'b1;

    assign o_result.valid       = r_out_valid;
    assign o_result.wiper_angle = r_angle;
    assign o_result.fast_speed  = r_fast;
    assign o_result.phase       = r_phase;

    // Register writes. Write data is cut to the width of each register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_below    <= OFF_RST;
            r_low_below    <= LOW_RST;
            r_int_below    <= INT_RST;
            r_short_below  <= SHORT_RST;
            r_medium_below <= MEDIUM_RST;
            r_short_pause  <= SHORT_PAUSE_RST;
            r_medium_pause <= MEDIUM_PAUSE_RST;
            r_long_pause   <= LONG_PAUSE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_OFF_BELOW:          r_off_below    <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_LOW_BELOW:          r_low_below    <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_INTERMITTENT_BELOW: r_int_below    <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_SHORT_BELOW:        r_short_below  <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_MEDIUM_BELOW:       r_medium_below <= i_cfg.data[LEVEL_BITS-1:0];
                CFG_SHORT_PAUSE_MS:     r_short_pause  <= i_cfg.data[MS_W-1:0];
                CFG_MEDIUM_PAUSE_MS:    r_medium_pause <= i_cfg.data[MS_W-1:0];
                CFG_LONG_PAUSE_MS:      r_long_pause   <= i_cfg.data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One tick of the sweep. The knob compares run in priority order, so
    // unordered thresholds simply let the first match win.
    always_comb begin
        t_mode           mode;
        t_sweep          cur;
        logic [MS_W-1:0] limit;
        logic [MS_W-1:0] pause;
        logic [MS_W-1:0] elapsed;
        logic [SUM_W-1:0] sum;

        if (i_tick.switch_level < r_off_below) begin
            mode = MODE_OFF;
        end else if (i_tick.switch_level < r_low_below) begin
            mode = MODE_LOW;
        end else if (i_tick.switch_level < r_int_below) begin
            mode = MODE_INT;
        end else begin
            mode = MODE_HIGH;
        end

        if (i_tick.pause_level < r_short_below) begin
            pause = r_short_pause;
        end else if (i_tick.pause_level < r_medium_below) begin
            pause = r_medium_pause;
        end else begin
            pause = r_long_pause;
        end

        cur        = r_sweep;
        n_fast_sel = r_fast_sel;
        n_fast     = 1'b0;
        case (mode)
            MODE_OFF:  cur = SW_HOLD;
            MODE_HIGH: begin
                n_fast_sel = 1'b1;
                n_fast     = 1'b1;
            end
            default:   n_fast_sel = 1'b0;
        endcase

        limit   = n_fast_sel ? HIGH_SWING_MS : LOW_SWING_MS;
        elapsed = r_elapsed;
        n_sweep = cur;
        n_angle = PARK_ANGLE;

        case (cur)
            SW_UP: begin
                n_angle = UP_ANGLE;
                if (elapsed > limit) begin
                    elapsed = '0;
                    n_angle = PARK_ANGLE;
                    n_sweep = SW_DOWN;
                end
            end
            SW_DOWN: begin
                if (elapsed > limit) begin
                    elapsed = '0;
                    n_sweep = SW_HOLD;
                end
            end
            default: begin
                // Hold. In intermittent mode wait out the pause; in any other
                // mode start the next sweep at once, keeping the timer.
                if (mode == MODE_INT) begin
                    if (elapsed > pause) begin
                        elapsed = '0;
                        n_sweep = SW_UP;
                    end
                end else begin
                    if (mode != MODE_OFF) begin
                        n_angle = UP_ANGLE;
                    end
                    n_sweep = SW_UP;
                end
            end
        endcase

        sum       = {1'b0, elapsed} + SUM_W'(TICK_MS);
        n_elapsed = sum[MS_W] ? COUNT_MAX : sum[MS_W-1:0];
        n_phase   = phase_code(n_sweep);

        // With the ignition off the wiper is parked and the state is frozen.
        if (!i_tick.ignition_on) begin
            n_angle = PARK_ANGLE;
            n_fast  = 1'b0;
            n_phase = phase_code(r_sweep);
        end
    end

    // Sweep state advances only on an accepted request with ignition on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= SW_HOLD;
            r_elapsed  <= '0;
            r_fast_sel <= 1'b0;
        end else if (tick_accept && i_tick.ignition_on) begin
            r_sweep    <= n_sweep;
            r_elapsed  <= n_elapsed;
            r_fast_sel <= n_fast_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_angle <= n_angle;
            r_fast  <= n_fast;
            r_phase <= n_phase;
        end
    end

endmodule : wiper_sweep_controller
`default_nettype wire

@@ sim/tb_wiper_sweep_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiper sweep controller testbench
// Streams knob ticks into the controller under random handshake gaps,
// predicts every servo command in step with the accepted requests and
// compares the results field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_wiper_sweep_controller;
    import wsc_pkg::*;

    localparam int LVL = LEVEL_BITS_DEF;

    // Register values after reset. The pause lengths come from the package,
    // the knob thresholds are fixed fractions of full scale.
    localparam logic [CFG_DATA_W-1:0] REG_DEFAULT [8] = '{
        16'd819, 16'd1638, 16'd2458, 16'd1352, 16'd2703,
        SHORT_PAUSE_RST, MEDIUM_PAUSE_RST, LONG_PAUSE_RST
    };

    // Long receiver hold-off that lets the block fill up and push back.
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic           ignition_on;
        logic [LVL-1:0] switch_level;
        logic [LVL-1:0] pause_level;
    } knob_tick_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] wiper_angle;
        logic               fast_speed;
        logic [PHASE_W-1:0] phase;
    } servo_cmd_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsc_tick_if #(.LEVEL_BITS(LVL)) tick_bus ();
    wsc_result_if                   res_bus ();
    wsc_cfg_if                      cfg_bus ();

    wiper_sweep_controller #(
        .LEVEL_BITS (LVL)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_bus),
        .o_result (res_bus),
        .i_cfg    (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and servo commands predicted for the
    // requests that the block has already taken.
    knob_tick_t tick_pending [$];
    servo_cmd_t servo_expected [$];

    // Stimulus-side copy of the register settings, used only to aim the knob
    // levels at the bands of the current thresholds.
    logic [CFG_DATA_W-1:0] plan_reg [8];

    // Predictor state: its own copy of the registers and of the sweep state.
    logic [CFG_DATA_W-1:0] knob_reg [8];
    logic [PHASE_W-1:0]    sweep_now;
    logic [MS_W-1:0]       ms_now;
    logic                  fast_now;

    // Control written by the stimulus process at falling edges only.
    logic idle_on;
    logic hold_armed;

    logic hold_done;
    int   hold_count;
    int   send_gap;
    int   recv_gap;
    int   mismatches = 0;

    // The 12-bit threshold registers drop the upper bits of the write data.
    function automatic logic [CFG_DATA_W-1:0] masked(t_cfg_idx idx,
                                                     logic [CFG_DATA_W-1:0] v);
        return (idx >= CFG_SHORT_PAUSE_MS) ? v : (v & 16'h0FFF);
    endfunction

    // One tick of the controller: decode the knobs, step the phase machine
    // and advance the saturating millisecond counter.
    function automatic servo_cmd_t predict_servo(knob_tick_t t);
        servo_cmd_t      c;
        t_mode           m;
        logic [MS_W-1:0] swing;
        logic [MS_W-1:0] pause;
        int unsigned     sum;
        c.wiper_angle = PARK_ANGLE;
        c.fast_speed  = 1'b0;
        // With the ignition off the wiper parks and nothing moves on.
        if (!t.ignition_on) begin
            c.phase = sweep_now;
            return c;
        end
        // Thresholds are tried in order as they stand, even when unordered.
        if (t.switch_level < knob_reg[CFG_OFF_BELOW])
            m = MODE_OFF;
        else if (t.switch_level < knob_reg[CFG_LOW_BELOW])
            m = MODE_LOW;
        else if (t.switch_level < knob_reg[CFG_INTERMITTENT_BELOW])
            m = MODE_INT;
        else
            m = MODE_HIGH;
        if (t.pause_level < knob_reg[CFG_SHORT_BELOW])
            pause = knob_reg[CFG_SHORT_PAUSE_MS];
        else if (t.pause_level < knob_reg[CFG_MEDIUM_BELOW])
            pause = knob_reg[CFG_MEDIUM_PAUSE_MS];
        else
            pause = knob_reg[CFG_LONG_PAUSE_MS];

        // Off forces hold and keeps the speed selection; high selects fast.
        case (m)
            MODE_OFF: begin
                sweep_now = PH_HOLD;
            end
            MODE_HIGH: begin
                fast_now     = 1'b1;
                c.fast_speed = 1'b1;
            end
            default: begin
                fast_now = 1'b0;
            end
        endcase

        swing = fast_now ? HIGH_SWING_MS : LOW_SWING_MS;
        if (sweep_now == PH_UP) begin
            c.wiper_angle = UP_ANGLE;
            if (ms_now > swing) begin
                ms_now        = '0;
                c.wiper_angle = PARK_ANGLE;
                sweep_now     = PH_DOWN;
            end
        end else if (sweep_now == PH_DOWN) begin
            if (ms_now > swing) begin
                ms_now    = '0;
                sweep_now = PH_HOLD;
            end
        end else begin
            // Hold, and the unused code treated as hold.
            if (m == MODE_INT) begin
                if (ms_now > pause) begin
                    ms_now    = '0;
                    sweep_now = PH_UP;
                end
            end else begin
                // Every mode but intermittent leaves hold at once and keeps the count.
                if (m != MODE_OFF)
                    c.wiper_angle = UP_ANGLE;
                sweep_now = PH_UP;
            end
        end

        sum    = ms_now + TICK_MS;
        ms_now = (sum > COUNT_MAX) ? COUNT_MAX : MS_W'(sum);
        c.phase = sweep_now;
        return c;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Pick a mode knob level inside the band of the requested mode under the
    // planned thresholds; an empty band falls back to any level.
    function automatic logic [LVL-1:0] band_level(t_mode m);
        int lo;
        int hi;
        case (m)
            MODE_OFF: begin
                lo = 0;
                hi = int'(plan_reg[CFG_OFF_BELOW]);
            end
            MODE_LOW: begin
                lo = int'(plan_reg[CFG_OFF_BELOW]);
                hi = int'(plan_reg[CFG_LOW_BELOW]);
            end
            MODE_INT: begin
                lo = int'(plan_reg[CFG_LOW_BELOW]);
                hi = int'(plan_reg[CFG_INTERMITTENT_BELOW]);
            end
            default: begin
                lo = int'(plan_reg[CFG_INTERMITTENT_BELOW]);
                hi = 1 << LVL;
            end
        endcase
        if (hi <= lo)
            return LVL'($urandom_range(0, (1 << LVL) - 1));
        return LVL'($urandom_range(lo, hi - 1));
    endfunction

    function automatic void queue_tick(logic ign, logic [LVL-1:0] sw, logic [LVL-1:0] pz);
        knob_tick_t t;
        t.ignition_on  = ign;
        t.switch_level = sw;
        t.pause_level  = pz;
        tick_pending.push_back(t);
    endfunction

    // Most ticks come in runs that hold one mode long enough to finish whole
    // sweeps and pauses; a few are noise or ignition drop-outs.
    task automatic queue_knob_runs(int n_ticks);
        int    left;
        int    run;
        int    r;
        t_mode m;
        logic [LVL-1:0] pz_hold;
        left = n_ticks;
        while (left > 0) begin
            m       = t_mode'($urandom_range(0, 3));
            run     = $urandom_range(1, 250);
            pz_hold = LVL'($urandom_range(0, (1 << LVL) - 1));
            if (run > left)
                run = left;
            for (int k = 0; k < run; k++) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    queue_tick(1'b0, LVL'($urandom_range(0, (1 << LVL) - 1)),
                               LVL'($urandom_range(0, (1 << LVL) - 1)));
                else if (r < 12)
                    queue_tick(1'b1, LVL'($urandom_range(0, (1 << LVL) - 1)),
                               LVL'($urandom_range(0, (1 << LVL) - 1)));
                else if (r < 20)
                    queue_tick(1'b1, band_level(m),
                               LVL'($urandom_range(0, (1 << LVL) - 1)));
                else
                    queue_tick(1'b1, band_level(m), pz_hold);
            end
            left -= run;
        end
    endtask

    // Register write over the configuration channel, driven at rising edges.
    task automatic set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        plan_reg[idx] = masked(idx, val);
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_all(logic [CFG_DATA_W-1:0] v0, logic [CFG_DATA_W-1:0] v1,
                           logic [CFG_DATA_W-1:0] v2, logic [CFG_DATA_W-1:0] v3,
                           logic [CFG_DATA_W-1:0] v4, logic [CFG_DATA_W-1:0] v5,
                           logic [CFG_DATA_W-1:0] v6, logic [CFG_DATA_W-1:0] v7);
        set_reg(CFG_OFF_BELOW, v0);
        set_reg(CFG_LOW_BELOW, v1);
        set_reg(CFG_INTERMITTENT_BELOW, v2);
        set_reg(CFG_SHORT_BELOW, v3);
        set_reg(CFG_MEDIUM_BELOW, v4);
        set_reg(CFG_SHORT_PAUSE_MS, v5);
        set_reg(CFG_MEDIUM_PAUSE_MS, v6);
        set_reg(CFG_LONG_PAUSE_MS, v7);
    endtask

    // Wait until every request has been taken and every result has come back.
    // Each request gives one registered result, so a short tail is enough.
    task automatic settle();
        while (tick_pending.size() != 0 || servo_expected.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Request driver. A request that is offered stays put until it is taken;
    // idle bursts only start between requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (tick_bus.valid && tick_bus.ready)
                void'(tick_pending.pop_front());
            if (tick_bus.valid && !tick_bus.ready) begin
                // Hold the current request.
            end else if (send_gap > 0) begin
                send_gap--;
                tick_bus.valid <= 1'b0;
            end else if (tick_pending.size() == 0) begin
                tick_bus.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 11) - 1;
                tick_bus.valid <= 1'b0;
            end else begin
                tick_bus.valid        <= 1'b1;
                tick_bus.ignition_on  <= tick_pending[0].ignition_on;
                tick_bus.switch_level <= tick_pending[0].switch_level;
                tick_bus.pause_level  <= tick_pending[0].pause_level;
            end
        end
    end

    // Predictor. Register writes and accepted requests are seen at the same
    // edges at which the block takes them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            knob_reg  = REG_DEFAULT;
            sweep_now = PH_HOLD;
            ms_now    = '0;
            fast_now  = 1'b0;
            servo_expected.delete();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready)
                knob_reg[cfg_bus.index] = masked(t_cfg_idx'(cfg_bus.index), cfg_bus.data);
            if (tick_bus.valid && tick_bus.ready)
                servo_expected.push_back(predict_servo({tick_bus.ignition_on,
                                                        tick_bus.switch_level,
                                                        tick_bus.pause_level}));
        end
    end

    // Long hold-off counter for the back-pressure test.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end
    end

    // Result monitor and receiver. Each result taken is checked against the
    // oldest prediction.
    always @(posedge i_clk) begin
        logic       go;
        servo_cmd_t want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (servo_expected.size() == 0) begin
                    flag_error("servo command with no request outstanding");
                end else begin
                    want = servo_expected.pop_front();
                    if (res_bus.wiper_angle !== want.wiper_angle)
                        flag_error($sformatf("wiper_angle %0d, expected %0d",
                                             res_bus.wiper_angle, want.wiper_angle));
                    if (res_bus.fast_speed !== want.fast_speed)
                        flag_error($sformatf("fast_speed %0b, expected %0b",
                                             res_bus.fast_speed, want.fast_speed));
                    if (res_bus.phase !== want.phase)
                        flag_error($sformatf("phase %0d, expected %0d",
                                             res_bus.phase, want.phase));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                go = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 11) - 1;
                go = 1'b0;
            end else begin
                go = 1'b1;
            end
            res_bus.ready <= go && !(hold_armed && !hold_done);
        end
    end

    // Stimulus and run control.
    initial begin
        tick_bus.valid        = 1'b0;
        tick_bus.ignition_on  = 1'b0;
        tick_bus.switch_level = '0;
        tick_bus.pause_level  = '0;
        res_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_OFF_BELOW;
        cfg_bus.data          = '0;
        idle_on               = 1'b1;
        hold_armed            = 1'b0;
        plan_reg              = REG_DEFAULT;
        i_rst_n               = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset settings: ignition off first, then
        // both sides of every mode threshold and every pause threshold, and
        // the all-zero and all-one knob levels.
        @(negedge i_clk);
        queue_tick(1'b0, 12'hFFF, 12'hFFF);
        queue_tick(1'b1, 12'h000, 12'h000);
        queue_tick(1'b1, 12'd818, 12'd100);
        queue_tick(1'b1, 12'd819, 12'd100);
        queue_tick(1'b1, 12'd1637, 12'd100);
        queue_tick(1'b1, 12'd1638, 12'd1351);
        queue_tick(1'b1, 12'd2457, 12'd1352);
        queue_tick(1'b1, 12'd2457, 12'd2702);
        queue_tick(1'b1, 12'd2457, 12'd2703);
        queue_tick(1'b1, 12'd2458, 12'hFFF);
        queue_tick(1'b1, 12'hFFF, 12'h000);
        queue_tick(1'b0, 12'h000, 12'h000);
        queue_tick(1'b1, 12'hFFF, 12'hFFF);
        queue_tick(1'b1, 12'h000, 12'hFFF);
        queue_tick(1'b0, 12'd2000, 12'd2000);
        queue_tick(1'b1, 12'd1000, 12'd0);
        queue_tick(1'b1, 12'd2000, 12'd4095);
        queue_tick(1'b1, 12'd3000, 12'd2000);
        settle();

        // Ordered thresholds with short pauses so that whole sweep cycles fit.
        // The upper nibble on the threshold writes must be dropped.
        set_all(16'hA258, 16'h55DC, 16'hFA28, 16'h33E8, 16'hCBB8,
                16'd0, 16'd40, 16'd200);
        @(negedge i_clk);
        queue_knob_runs(400);
        settle();

        // Back-pressure: the receiver stops for a long stretch while ticks
        // keep coming, so the output register fills and input ready drops.
        hold_armed = 1'b1;
        queue_knob_runs(150);
        settle();
        hold_armed = 1'b0;

        // Unordered thresholds: the first compare that matches wins. One
        // pause is the maximum, which can never be exceeded.
        set_all(16'd3000, 16'd1000, 16'd2000, 16'd3500, 16'd500,
                16'hFFFF, 16'd30, 16'd0);
        @(negedge i_clk);
        queue_knob_runs(300);
        settle();

        // Extremes: zero and full-scale thresholds and pauses, top level only for high.
        set_all(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                16'd0, 16'd0, 16'hFFFF);
        @(negedge i_clk);
        queue_knob_runs(200);
        settle();

        // All thresholds at full scale: nearly every level reads as off.
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF);
        @(negedge i_clk);
        queue_knob_runs(150);
        settle();

        // Maximum pause. With the short pause at the ceiling the wiper sits
        // in hold through an intermittent stretch; a pause one below the
        // ceiling keeps it there, and a zero long pause then lets it leave.
        set_all(16'd819, 16'd1638, 16'd2458, 16'd2048, 16'd4095,
                16'hFFFF, 16'hFFFE, 16'd0);
        @(negedge i_clk);
        for (int k = 0; k < 120; k++) begin
            if ($urandom_range(0, 49) == 0)
                queue_tick(1'b0, LVL'($urandom_range(0, 4095)),
                           LVL'($urandom_range(0, 4095)));
            else
                queue_tick(1'b1, band_level(MODE_INT), LVL'($urandom_range(0, 2047)));
        end
        for (int k = 0; k < 10; k++)
            queue_tick(1'b1, band_level(MODE_INT), LVL'($urandom_range(2048, 4094)));
        queue_tick(1'b1, band_level(MODE_INT), 12'hFFF);
        settle();

        // Closing stretch at full rate with no gaps on either side.
        set_all(16'd700, 16'd1400, 16'd2800, 16'd1200, 16'd2600,
                16'd20, 16'd90, 16'd160);
        @(negedge i_clk);
        idle_on = 1'b0;
        queue_knob_runs(300);
        settle();

        repeat (5) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ wiper_sweep_controller.f @@
rtl/wsc_pkg.sv
rtl/wsc_if.sv
rtl/wiper_sweep_controller.sv
sim/tb_wiper_sweep_controller.sv
